@@ rtl/psfoc_pkg.sv @@
package psfoc_pkg;

  // Field widths of the request, the result and the calibration words.
  localparam int unsigned RawW     = 24;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned TempW    = 19;
  localparam int unsigned PresW    = 24;
  localparam int unsigned CfgIdxW  = 3;

  // Internal widths, sized to the extreme values of the formulas.
  localparam int unsigned DtW      = 25;  // raw temperature minus reference
  localparam int unsigned MulW     = 41;  // dT times a 16-bit coefficient
  localparam int unsigned OffW     = 35;  // pressure offset
  localparam int unsigned SensW    = 35;  // pressure sensitivity
  localparam int unsigned SensLoW  = 17;  // low slice of sensitivity
  localparam int unsigned SensHiW  = SensW - SensLoW;
  localparam int unsigned PlW      = RawW + SensLoW;      // unsigned partial product
  localparam int unsigned PhW      = RawW + 1 + SensHiW;  // signed partial product
  localparam int unsigned ProdW    = 60;  // raw pressure times sensitivity
  localparam int unsigned DiffW    = 40;  // scaled product minus offset

  // Base temperature, 20.00 degrees Celsius.
  localparam int unsigned TempBase = 2000;

  // Calibration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    RegPressureSensitivity  = 3'd0,
    RegPressureOffset       = 3'd1,
    RegSensitivityTempCoeff = 3'd2,
    RegOffsetTempCoeff      = 3'd3,
    RegReferenceTemperature = 3'd4,
    RegTemperatureSlope     = 3'd5
  } cfg_idx_e;

  // The six calibration words.
  typedef struct packed {
    logic [CoefW-1:0] pressure_sensitivity;
    logic [CoefW-1:0] pressure_offset;
    logic [CoefW-1:0] sensitivity_temp_coeff;
    logic [CoefW-1:0] offset_temp_coeff;
    logic [CoefW-1:0] reference_temperature;
    logic [CoefW-1:0] temperature_slope;
  } cal_t;

  // Request state between the coefficient half and the pressure half.
  typedef struct packed {
    logic             valid;
    logic [RawW-1:0]  raw_pressure;
    logic [TempW-1:0] temperature_centi;
    logic [OffW-1:0]  off;
    logic [SensW-1:0] sens;
  } comp_t;

endpackage

@@ rtl/psfoc_cfg_regs.sv @@
module psfoc_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [psfoc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [psfoc_pkg::CoefW-1:0]       cfg_wdata_i,
  output psfoc_pkg::cal_t                   cal_o
);

  psfoc_pkg::cal_t cal_q;
  psfoc_pkg::cal_t cal_d;

  // Decode the register index; unknown indexes leave every word alone.
  always_comb begin
    cal_d = cal_q;
    if (cfg_we_i) begin
      case (psfoc_pkg::cfg_idx_e'(cfg_index_i))
        psfoc_pkg::RegPressureSensitivity:  cal_d.pressure_sensitivity   = cfg_wdata_i;
        psfoc_pkg::RegPressureOffset:       cal_d.pressure_offset        = cfg_wdata_i;
        psfoc_pkg::RegSensitivityTempCoeff: cal_d.sensitivity_temp_coeff = cfg_wdata_i;
        psfoc_pkg::RegOffsetTempCoeff:      cal_d.offset_temp_coeff      = cfg_wdata_i;
        psfoc_pkg::RegReferenceTemperature: cal_d.reference_temperature  = cfg_wdata_i;
        psfoc_pkg::RegTemperatureSlope:     cal_d.temperature_slope      = cfg_wdata_i;
        default: cal_d = cal_q;
      endcase
    end
  end

  // Calibration words reset to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

  assign cal_o = cal_q;

endmodule

@@ rtl/psfoc_coef.sv @@
module psfoc_coef (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [psfoc_pkg::RawW-1:0]    raw_pressure_i,
  input  logic [psfoc_pkg::RawW-1:0]    raw_temperature_i,
  input  psfoc_pkg::cal_t               cal_i,
  output psfoc_pkg::comp_t              comp_o
);

  // Stage 1: temperature difference.
  logic                                v1_q;
  logic [psfoc_pkg::RawW-1:0]          p1_q;
  logic signed [psfoc_pkg::DtW-1:0]    dt_d;
  logic signed [psfoc_pkg::DtW-1:0]    dt_q;

  // Stage 2: the three products of dT.
  logic                                v2_q;
  logic [psfoc_pkg::RawW-1:0]          p2_q;
  logic signed [psfoc_pkg::MulW-1:0]   mt_d, mo_d, ms_d;
  logic signed [psfoc_pkg::MulW-1:0]   mt_q, mo_q, ms_q;

  // Stage 3: temperature, offset and sensitivity.
  logic signed [psfoc_pkg::TempW-1:0]  temp_d;
  logic signed [psfoc_pkg::OffW-1:0]   off_d;
  logic signed [psfoc_pkg::SensW-1:0]  sens_d;
  logic                                v3_q;
  logic [psfoc_pkg::RawW-1:0]          p3_q;
  logic [psfoc_pkg::TempW-1:0]         t3_q;
  logic [psfoc_pkg::OffW-1:0]          off3_q;
  logic [psfoc_pkg::SensW-1:0]         sens3_q;

  // dT = raw temperature minus the reference scaled by 256.
  assign dt_d = $signed({1'b0, raw_temperature_i})
              - $signed({1'b0, cal_i.reference_temperature, 8'b0});

  // Each coefficient is taken as a positive signed operand.
  assign mt_d = dt_q * $signed({1'b0, cal_i.temperature_slope});
  assign mo_d = dt_q * $signed({1'b0, cal_i.offset_temp_coeff});
  assign ms_d = dt_q * $signed({1'b0, cal_i.sensitivity_temp_coeff});

  // Arithmetic shifts are taken as the upper bits of each product.
  assign temp_d = $signed({mt_q[psfoc_pkg::MulW-1], mt_q[psfoc_pkg::MulW-1:23]})
                + $signed(psfoc_pkg::TempW'(psfoc_pkg::TempBase));
  assign off_d  = $signed({3'b000, cal_i.pressure_offset, 16'b0})
                + $signed({mo_q[psfoc_pkg::MulW-1], mo_q[psfoc_pkg::MulW-1:7]});
  assign sens_d = $signed({4'b0000, cal_i.pressure_sensitivity, 15'b0})
                + $signed({{2{ms_q[psfoc_pkg::MulW-1]}}, ms_q[psfoc_pkg::MulW-1:8]});

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Payload registers of the three stages.
  always_ff @(posedge clk_i) begin
    p1_q    <= raw_pressure_i;
    dt_q    <= dt_d;
    p2_q    <= p1_q;
    mt_q    <= mt_d;
    mo_q    <= mo_d;
    ms_q    <= ms_d;
    p3_q    <= p2_q;
    t3_q    <= temp_d;
    off3_q  <= off_d;
    sens3_q <= sens_d;
  end

  // Hand the stage 3 request to the pressure half.
  always_comb begin
    comp_o.valid             = v3_q;
    comp_o.raw_pressure      = p3_q;
    comp_o.temperature_centi = t3_q;
    comp_o.off               = off3_q;
    comp_o.sens              = sens3_q;
  end

endmodule

@@ rtl/psfoc_pres.sv @@
module psfoc_pres (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  psfoc_pkg::comp_t              comp_i,
  output logic                          valid_o,
  output logic [psfoc_pkg::TempW-1:0]   temperature_centi_o,
  output logic [psfoc_pkg::PresW-1:0]   pressure_comp_o
);

  // Stage 4: two partial products of raw pressure times sensitivity.
  logic                                v4_q;
  logic [psfoc_pkg::TempW-1:0]         t4_q;
  logic [psfoc_pkg::OffW-1:0]          off4_q;
  logic [psfoc_pkg::PlW-1:0]           plo_d, plo_q;
  logic signed [psfoc_pkg::PhW-1:0]    phi_d, phi_q;

  // Stage 5: full product.
  logic                                v5_q;
  logic [psfoc_pkg::TempW-1:0]         t5_q;
  logic [psfoc_pkg::OffW-1:0]          off5_q;
  logic signed [psfoc_pkg::ProdW-1:0]  prod_d, prod_q;

  // Stage 6: offset removal and final scaling.
  logic signed [psfoc_pkg::DiffW-1:0]  diff_d;
  logic                                v6_q;
  logic [psfoc_pkg::TempW-1:0]         t6_q;
  logic [psfoc_pkg::PresW-1:0]         p6_q;

  // Split sensitivity into an unsigned low slice and a signed high slice.
  assign plo_d = comp_i.raw_pressure * comp_i.sens[psfoc_pkg::SensLoW-1:0];
  assign phi_d = $signed({1'b0, comp_i.raw_pressure})
               * $signed(comp_i.sens[psfoc_pkg::SensW-1:psfoc_pkg::SensLoW]);

  // Recombine the partial products.
  assign prod_d = ($signed(psfoc_pkg::ProdW'(phi_q)) <<< psfoc_pkg::SensLoW)
                + $signed(psfoc_pkg::ProdW'(plo_q));

  // Product shifted down by 21, minus the offset; the final shift by 15 is a slice.
  assign diff_d = $signed({prod_q[psfoc_pkg::ProdW-1], prod_q[psfoc_pkg::ProdW-1:21]})
                - $signed({{5{off5_q[psfoc_pkg::OffW-1]}}, off5_q});

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v4_q <= comp_i.valid;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // Payload registers of the three stages.
  always_ff @(posedge clk_i) begin
    t4_q   <= comp_i.temperature_centi;
    off4_q <= comp_i.off;
    plo_q  <= plo_d;
    phi_q  <= phi_d;
    t5_q   <= t4_q;
    off5_q <= off4_q;
    prod_q <= prod_d;
    t6_q   <= t5_q;
    p6_q   <= diff_d[psfoc_pkg::PresW+14:15];
  end

  assign valid_o             = v6_q;
  assign temperature_centi_o = t6_q;
  assign pressure_comp_o     = p6_q;

endmodule

@@ rtl/pressure_sensor_first_order_compensation.sv @@
// First-order temperature compensation for a barometric pressure sensor.
//
// A request is one raw 24-bit pressure conversion and one raw 24-bit
// temperature conversion, taken at a rising edge where start is high and
// busy is low. busy is always low: the block is a six-stage pipeline and
// takes a new request in every cycle, so the throughput is one request
// per clock.
// Each request gives one result: temperature_centi_o (hundredths of a
// degree Celsius) and pressure_comp_o, both two's complement. The result
// is shown for exactly one cycle with result_valid_o high, once the
// request has passed the three coefficient stages and the three
// pressure stages that multiply by sensitivity and remove the offset.
// Results come in request order.
// The receiver cannot hold results off, so nothing ever stalls.
// Calibration words are written through cfg_we_i, cfg_index_i and
// cfg_wdata_i; the user must do so only while no request is in flight
// (the block does not enforce it). Indexes above five are ignored. Reset
// clears the calibration words and all valid bits; requests in flight drop.
module pressure_sensor_first_order_compensation (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [psfoc_pkg::RawW-1:0]         raw_pressure_i,
  input  logic [psfoc_pkg::RawW-1:0]         raw_temperature_i,
  output logic                               result_valid_o,
  output logic signed [psfoc_pkg::TempW-1:0] temperature_centi_o,
  output logic signed [psfoc_pkg::PresW-1:0] pressure_comp_o,
  input  logic                               cfg_we_i,
  input  logic [psfoc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [psfoc_pkg::CoefW-1:0]        cfg_wdata_i
);

  psfoc_pkg::cal_t  cal;
  psfoc_pkg::comp_t comp;
  logic             req_valid;
  logic [psfoc_pkg::TempW-1:0] temp_res;
  logic [psfoc_pkg::PresW-1:0] pres_res;

  // The pipeline never stalls.
  assign busy      = 1'b0;
  assign req_valid = start & ~busy;

  // Calibration words.
  psfoc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cal_o       (cal)
  );

  // Temperature difference, temperature, offset and sensitivity.
  psfoc_coef u_coef (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (req_valid),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .cal_i             (cal),
    .comp_o            (comp)
  );

  // Compensated pressure.
  psfoc_pres u_pres (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .comp_i              (comp),
    .valid_o             (result_valid_o),
    .temperature_centi_o (temp_res),
    .pressure_comp_o     (pres_res)
  );

  assign temperature_centi_o = $signed(temp_res);
  assign pressure_comp_o     = $signed(pres_res);

endmodule
